// ===== src/ptt_pkg.sv =====
package ptt_pkg;

  localparam int POS_BITS    = 16;
  localparam int NAME_BITS   = 16;
  localparam int CMD_BITS    = 3;
  localparam int STATUS_BITS = 3;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_FIND     = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_NEXT     = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_MOVE     = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_NEW_PAGE = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FIRED     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_PAGE      = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND  = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_UNLIMITED = 3'd6;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PAGE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRAPS_EN    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EVEN_OFFSET = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ODD_OFFSET  = 2'd3;

  localparam logic [POS_BITS-1:0] POS_ALL_ONES = '1;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [NAME_BITS-1:0] trap_name;
    logic [POS_BITS-1:0]  position;
    logic                 any_position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [NAME_BITS-1:0]   fired_name;
    logic [POS_BITS-1:0]    result_position;
    logic [POS_BITS-1:0]    space_lost;
    logic [15:0]            page_num;
    logic [15:0]            page_offset;
  } out_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]  pos;
    logic [NAME_BITS-1:0] name;
  } entry_t;

endpackage

// ===== src/position_trap_table_core.sv =====
// Path, accept to out_valid: a full table, disabled traps, a direct page end and unused
//   commands go straight to S_REPORT; next/move/new page read the pending trap (S_RD_PEND,
//   S_EVAL); find scans; remove scans, then shifts down; add scans, then shifts up.
// Items: one at a time; busy is high from accept until the result strobe, so a new item is
//   taken only after the last result. Results are strobed once; the receiver cannot stall.
// Reset (synchronous, rst_n low) resets counters, cursor, page state and config, not the table.
module position_trap_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ptt_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  output ptt_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [ptt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ptt_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_UP, S_INSERT, S_SHIFT_DN, S_RD_PEND, S_EVAL, S_REPORT
  } state_t;

  state_t state_r;
  ptt_pkg::in_item_t item_r;
  logic [CW-1:0] cnt_r, pend_r, idx_r, hit_r;
  logic [ptt_pkg::POS_BITS-1:0] vpos_r, plen_r, even_r, odd_r, offset_r;
  logic [15:0] page_r, npage_r;
  logic ten_r;

  logic [ptt_pkg::STATUS_BITS-1:0] st_r;
  logic [ptt_pkg::NAME_BITS-1:0]   fired_r;
  logic [ptt_pkg::POS_BITS-1:0]    lost_r, rpos_r;
  logic                            rpos_own_r;
  logic                            out_valid_r;
  ptt_pkg::out_item_t              out_item_r;

  // trap memory
  ptt_pkg::entry_t mem [TABLE_DEPTH];
  ptt_pkg::entry_t rd_data_r;
  logic            rd_vld_r;
  logic [IW-1:0]   rd_idx_r;

  logic            mem_re, mem_we;
  logic [IW-1:0]   mem_raddr, mem_waddr;
  ptt_pkg::entry_t mem_wdata;

  logic scan_match, scan_hit;
  logic [ptt_pkg::POS_BITS-1:0] ev_tp, ev_target, ev_nv, ev_lost;
  logic ev_trap_ok;

  always_comb begin
    case (item_r.command)
      ptt_pkg::CMD_ADD:    scan_match = rd_data_r.pos > item_r.position;
      ptt_pkg::CMD_REMOVE: scan_match = (rd_data_r.name == item_r.trap_name) &&
                                        (item_r.any_position ||
                                         rd_data_r.pos == item_r.position);
      default:             scan_match = rd_data_r.name == item_r.trap_name;
    endcase
    scan_hit = rd_vld_r && scan_match;
  end

  always_comb begin
    ev_tp      = rd_data_r.pos;
    ev_trap_ok = (pend_r < cnt_r) && (ev_tp < plen_r);
    ev_target  = (item_r.command == ptt_pkg::CMD_MOVE) ? item_r.position : plen_r;
    ev_nv      = (ev_tp > vpos_r) ? ev_tp : vpos_r;
    ev_lost    = (ev_target > ev_nv) ? ev_target - ev_nv : '0;
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data_r;
    case (state_r)
      S_SCAN: begin
        mem_re    = (idx_r < cnt_r) && !scan_hit;
        mem_raddr = idx_r[IW-1:0];
      end
      S_SHIFT_UP: begin
        // read i-1 while writing the entry read last cycle one slot higher
        mem_re    = idx_r > hit_r;
        mem_raddr = IW'(idx_r - 1'b1);
        mem_we    = rd_vld_r;
        mem_waddr = IW'(rd_idx_r + 1'b1);
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = hit_r[IW-1:0];
        mem_wdata = '{pos: item_r.position, name: item_r.trap_name};
      end
      S_SHIFT_DN: begin
        mem_re    = idx_r < cnt_r;
        mem_raddr = idx_r[IW-1:0];
        mem_we    = rd_vld_r;
        mem_waddr = IW'(rd_idx_r - 1'b1);
      end
      S_RD_PEND: begin
        mem_re    = 1'b1;
        mem_raddr = pend_r[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
    rd_idx_r <= mem_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= '0;
      vpos_r      <= '0;
      page_r      <= '0;
      npage_r     <= 16'd1;
      offset_r    <= '0;
      plen_r      <= '1;
      ten_r       <= 1'b1;
      even_r      <= '0;
      odd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ptt_pkg::CFG_PAGE_LENGTH: plen_r <= cfg_data;
          ptt_pkg::CFG_TRAPS_EN:    ten_r  <= cfg_data[0];
          ptt_pkg::CFG_EVEN_OFFSET: even_r <= cfg_data;
          ptt_pkg::CFG_ODD_OFFSET:  odd_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r     <= in_item;
            st_r       <= ptt_pkg::ST_DONE;
            fired_r    <= '0;
            lost_r     <= '0;
            rpos_own_r <= 1'b0;
            idx_r      <= '0;
            state_r    <= S_REPORT;
            case (in_item.command)
              ptt_pkg::CMD_ADD: begin
                if (cnt_r >= MAX_CNT) begin
                  st_r <= ptt_pkg::ST_FULL;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              ptt_pkg::CMD_REMOVE, ptt_pkg::CMD_FIND: begin
                state_r <= S_SCAN;
              end
              ptt_pkg::CMD_NEXT: begin
                if (!ten_r) begin
                  st_r       <= ptt_pkg::ST_UNLIMITED;
                  rpos_r     <= ptt_pkg::POS_ALL_ONES;
                  rpos_own_r <= 1'b1;
                end else begin
                  state_r <= S_RD_PEND;
                end
              end
              ptt_pkg::CMD_MOVE: begin
                if (!ten_r) begin
                  vpos_r <= in_item.position;
                end else begin
                  state_r <= S_RD_PEND;
                end
              end
              ptt_pkg::CMD_NEW_PAGE: begin
                if (vpos_r < plen_r) begin
                  if (!ten_r) begin
                    vpos_r <= plen_r;
                  end else begin
                    state_r <= S_RD_PEND;
                  end
                end else begin
                  st_r     <= ptt_pkg::ST_PAGE;
                  vpos_r   <= '0;
                  page_r   <= npage_r;
                  npage_r  <= npage_r + 16'd1;
                  offset_r <= npage_r[0] ? odd_r : even_r;
                  pend_r   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit_r <= CW'(rd_idx_r);
            case (item_r.command)
              ptt_pkg::CMD_ADD: begin
                idx_r   <= cnt_r;
                state_r <= S_SHIFT_UP;
              end
              ptt_pkg::CMD_REMOVE: begin
                if (pend_r > CW'(rd_idx_r)) begin
                  pend_r <= pend_r - 1'b1;
                end
                idx_r   <= CW'(rd_idx_r) + 1'b1;
                state_r <= S_SHIFT_DN;
              end
              default: begin
                st_r       <= ptt_pkg::ST_FOUND;
                rpos_r     <= rd_data_r.pos;
                rpos_own_r <= 1'b1;
                state_r    <= S_REPORT;
              end
            endcase
          end else if (idx_r >= cnt_r && !rd_vld_r) begin
            // scanned everything, no hit
            case (item_r.command)
              ptt_pkg::CMD_ADD: begin
                hit_r   <= cnt_r;
                idx_r   <= cnt_r;
                state_r <= S_SHIFT_UP;
              end
              ptt_pkg::CMD_REMOVE: begin
                st_r    <= ptt_pkg::ST_NOTFOUND;
                state_r <= S_REPORT;
              end
              default: begin
                st_r       <= ptt_pkg::ST_NOTFOUND;
                rpos_r     <= ptt_pkg::POS_ALL_ONES;
                rpos_own_r <= 1'b1;
                state_r    <= S_REPORT;
              end
            endcase
          end else if (mem_re) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SHIFT_UP: begin
          if (mem_re) begin
            idx_r <= idx_r - 1'b1;
          end else if (!rd_vld_r) begin
            state_r <= S_INSERT;
          end
        end
        S_INSERT: begin
          cnt_r <= cnt_r + 1'b1;
          // new trap already behind the page position: cursor skips it
          if (hit_r == pend_r && item_r.position < vpos_r) begin
            pend_r <= pend_r + 1'b1;
          end
          state_r <= S_REPORT;
        end
        S_SHIFT_DN: begin
          if (mem_re) begin
            idx_r <= idx_r + 1'b1;
          end else if (!rd_vld_r) begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_REPORT;
          end
        end
        S_RD_PEND: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          state_r <= S_REPORT;
          if (item_r.command == ptt_pkg::CMD_NEXT) begin
            rpos_r     <= ev_trap_ok ? ev_tp : plen_r;
            rpos_own_r <= 1'b1;
          end else if (ev_trap_ok && ev_target >= ev_tp) begin
            st_r    <= ptt_pkg::ST_FIRED;
            vpos_r  <= ev_nv;
            lost_r  <= ev_lost;
            fired_r <= rd_data_r.name;
            pend_r  <= pend_r + 1'b1;
          end else if (ev_target >= plen_r) begin
            st_r     <= ptt_pkg::ST_PAGE;
            vpos_r   <= '0;
            page_r   <= npage_r;
            npage_r  <= npage_r + 16'd1;
            offset_r <= npage_r[0] ? odd_r : even_r;
            pend_r   <= '0;
          end else begin
            vpos_r <= ev_target;
          end
        end
        S_REPORT: begin
          out_item_r <= '{status: st_r, fired_name: fired_r,
                          result_position: rpos_own_r ? rpos_r : vpos_r,
                          space_lost: lost_r, page_num: page_r,
                          page_offset: offset_r};
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT) else $error("trap count past table depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= cnt_r) else $error("pending cursor past entry count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(state_r == S_REPORT))
    else $error("result strobe outside report");

  a_read_owned: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r != S_IDLE && state_r != S_REPORT)
    else $error("memory read left unconsumed");

endmodule
